### rtl/core/pad_pkg.sv
package pad_pkg;

    localparam int CHAN_W         = 3;
    localparam int SAMPLE_W       = 10;
    localparam int LEVEL_W        = 7;
    localparam int DROP_BITS      = SAMPLE_W - LEVEL_W;
    localparam int CHANNELS_DEF   = 8;
    localparam int RING_DEPTH_DEF = 8;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic [LEVEL_W-1:0] level;
    } t_out_item;

endpackage

### rtl/core/pad_level_track.sv
module pad_level_track #(
    parameter int CHANNELS   = pad_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH = pad_pkg::RING_DEPTH_DEF,
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_upd,
    input  logic [CH_W-1:0]             i_ch,
    input  logic [pad_pkg::LEVEL_W-1:0] i_old,
    input  logic [pad_pkg::LEVEL_W-1:0] i_value,
    output logic                        o_report,
    output logic [pad_pkg::LEVEL_W-1:0] o_mean
);
    import pad_pkg::*;

    localparam int SUM_W      = LEVEL_W + $clog2(RING_DEPTH);
    localparam int MEAN_SHIFT = 16;
    localparam int RECIP      = ((1 << MEAN_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam int PROD_W     = MEAN_SHIFT + LEVEL_W;
    localparam int MAX_SUM    = ((1 << LEVEL_W) - 1) * RING_DEPTH;

    logic [SUM_W-1:0]   r_sum   [CHANNELS];
    logic [LEVEL_W-1:0] r_cur   [CHANNELS];
    logic [LEVEL_W-1:0] r_prior [CHANNELS];

    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] w_prod;

    // The mean is a multiply by a rounded-up reciprocal; exact for every reachable sum.
    always_comb begin
        n_sum    = r_sum[i_ch] - SUM_W'(i_old) + SUM_W'(i_value);
        w_prod   = PROD_W'(n_sum) * PROD_W'(RECIP);
        o_mean   = w_prod[MEAN_SHIFT +: LEVEL_W];
        o_report = (o_mean != r_cur[i_ch]) && (o_mean != r_prior[i_ch]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i]   <= '0;
                r_cur[i]   <= '0;
                r_prior[i] <= '0;
            end
        end else if (i_upd) begin
            r_sum[i_ch] <= n_sum;
            if (o_report) begin
                r_prior[i_ch] <= r_cur[i_ch];
                r_cur[i_ch]   <= o_mean;
            end
        end
    end

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd |-> (n_sum <= SUM_W'(MAX_SUM)))
        else $error("running sum exceeds the largest possible ring total");

    a_report_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && o_report) |=> (r_cur[$past(i_ch)] == $past(o_mean))
            && (r_prior[$past(i_ch)] == $past(r_cur[i_ch])))
        else $error("reported level not committed to the channel");

    a_quiet_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && !o_report) |=> (r_cur[$past(i_ch)] == $past(r_cur[i_ch])))
        else $error("current level changed without a report");

endmodule

### rtl/core/pot_average_dither_filter.sv
// An accepted item is held in the working stage, a reported result then in the output
// register. Throughput: one item per cycle while o_stall is low; the ring read is
// registered at acceptance, and the sum, mean and hysteresis decision are formed in the following cycle.
// Reset: synchronous, active low; clears ring pointers, sums, levels and the ring
// valid bits, so ring entries not yet written read as zero. No clearing pass is needed.
module pot_average_dither_filter #(
    parameter int CHANNELS   = pad_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH = pad_pkg::RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pad_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output pad_pkg::t_out_item o_item
);
    import pad_pkg::*;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W  = $clog2(RING_DEPTH);
    localparam int ENTRIES = CHANNELS * RING_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    logic [SLOT_W-1:0]  r_slot [CHANNELS];
    logic [LEVEL_W-1:0] r_ring_mem [ENTRIES];
    logic [ENTRIES-1:0] r_ring_vld;

    logic               r_s1_valid;
    logic [CH_W-1:0]    r_s1_ch;
    logic [LEVEL_W-1:0] r_s1_value;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [LEVEL_W-1:0] r_rd_data;
    logic               r_rd_vld;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_in_range;
    logic               w_take;
    logic [CH_W-1:0]    w_ch_idx;
    logic [SLOT_W-1:0]  w_slot;
    logic [ADDR_W-1:0]  w_addr;
    logic [LEVEL_W-1:0] w_old;
    logic               w_report;
    logic [LEVEL_W-1:0] w_mean;
    logic               w_s1_adv;

    always_comb begin
        w_in_range = int'(i_item.channel) < CHANNELS;
        w_ch_idx   = CH_W'(i_item.channel);
        w_slot     = r_slot[w_ch_idx];
        w_addr     = ADDR_W'(w_ch_idx) * ADDR_W'(RING_DEPTH) + ADDR_W'(w_slot);
        w_old      = r_rd_vld ? r_rd_data : '0;
        w_s1_adv   = r_s1_valid && (!r_out_valid || !i_stall || !w_report);
        o_stall    = r_s1_valid && !w_s1_adv;
        w_take     = i_valid && !o_stall && w_in_range;
        o_valid    = r_out_valid;
        o_item     = r_out;
    end

    pad_level_track #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (w_s1_adv),
        .i_ch     (r_s1_ch),
        .i_old    (w_old),
        .i_value  (r_s1_value),
        .o_report (w_report),
        .o_mean   (w_mean)
    );

    // The ring pointer advances at acceptance, so a following item of the same
    // channel reads the next slot without forwarding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_slot[i] <= '0;
            end
            r_ring_vld  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_slot[w_ch_idx] <= (w_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : w_slot + 1'b1;
            end
            if (w_s1_adv) begin
                r_ring_vld[r_s1_addr] <= 1'b1;
            end
            if (w_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv && w_report) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_ch    <= w_ch_idx;
            r_s1_value <= i_item.sample[DROP_BITS +: LEVEL_W];
            r_s1_addr  <= w_addr;
            r_rd_data  <= r_ring_mem[w_addr];
            r_rd_vld   <= r_ring_vld[w_addr];
        end
        if (w_s1_adv) begin
            r_ring_mem[r_s1_addr] <= r_s1_value;
        end
        if (w_s1_adv && w_report) begin
            r_out.out_channel <= CHAN_W'(r_s1_ch);
            r_out.level       <= w_mean;
        end
    end

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input held off without a blocked result");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_s1_valid)
        else $error("accepted item did not reach the working stage");

    a_report_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_report) |=> (o_valid && (o_item.level == $past(w_mean))))
        else $error("reported level not presented on the output");

endmodule
